// File: sv/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table engine package
// Shared field widths, operation codes and the result record type.
// ----------------------------------------------------------------------------
package ste_pkg;

   localparam int FUNC_W = 3;
   localparam int IDX_W  = 4;
   localparam int DATA_W = 32;
   localparam int CNT_W  = 5;
   localparam int SIZE_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [IDX_W-1:0]  result_index;
      logic              found;
      logic              index_error;
      logic [CNT_W-1:0]  occupied_count;
      logic              has_empty;
   } ste_result_type;

endpackage

// File: sv/ste_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table engine channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface ste_req_if;
   logic                       valid;
   logic                       ready;
   logic [ste_pkg::FUNC_W-1:0] func;
   logic [ste_pkg::IDX_W-1:0]  slot_index;
   logic [ste_pkg::DATA_W-1:0] slot_value;

   modport source (output valid, func, slot_index, slot_value, input ready);
   modport sink (input valid, func, slot_index, slot_value, output ready);
endinterface

interface ste_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ste_pkg::DATA_W-1:0] read_value;
   logic [ste_pkg::IDX_W-1:0]  result_index;
   logic                       found;
   logic                       index_error;
   logic [ste_pkg::CNT_W-1:0]  occupied_count;
   logic                       has_empty;

   modport source (output valid, read_value, result_index, found, index_error,
                   occupied_count, has_empty, input ready);
   modport sink (input valid, read_value, result_index, found, index_error,
                 occupied_count, has_empty, output ready);
endinterface

// File: sv/ste_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table engine store
// Single-port-write, single-port-read slot memory with a registered read.
// ----------------------------------------------------------------------------
module ste_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/ste_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table engine sequencer
// Clears the store after reset, runs one transaction at a time through
// read-modify-write or a top-down scan, and keeps the occupied count.
// ----------------------------------------------------------------------------
module ste_seq #(
   parameter int SLOTS       = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int AW          = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ste_pkg::SIZE_W-1:0] eff_size,
   ste_req_if.sink                    req_ch,
   ste_rsp_if.source                  rsp_ch,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [VALUE_WIDTH-1:0]     mem_rd_data,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [VALUE_WIDTH-1:0]     mem_wr_data
);

   localparam int OW = $clog2(SLOTS + 1);
   localparam int SW = ste_pkg::SIZE_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [AW-1:0]                    clr_ff, clr_in;
   logic [ste_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0]           val_ff, val_in;
   logic [SW-1:0]                    pos_ff, pos_in;
   logic [OW-1:0]                    occ_ff, occ_in;
   ste_pkg::ste_result_type          res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ste_pkg::ste_result_type          rsp_data_ff, rsp_data_in;

   logic [63:0]                      req_val_wide;
   logic [63:0]                      rd_wide;
   logic [VALUE_WIDTH-1:0]           target;
   logic                             hit;
   logic                             idx_ok;
   logic [VALUE_WIDTH-1:0]           new_val;

   assign req_val_wide = 64'(req_ch.slot_value);
   assign rd_wide      = 64'(mem_rd_data);
   assign idx_ok       = {1'b0, req_ch.slot_index} < eff_size;
   assign target       = (func_ff == ste_pkg::FUNC_ADD) ? '0 : val_ff;
   assign hit          = mem_rd_data == target;
   assign new_val      = (func_ff == ste_pkg::FUNC_SET) ? val_ff : '0;

   assign req_ch.ready = state_ff == ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(req_ch.slot_index);
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = val_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in = req_ch.func;
               idx_in  = AW'(req_ch.slot_index);
               val_in  = req_val_wide[VALUE_WIDTH-1:0];
               res_in  = '0;
               case (req_ch.func) inside
                  ste_pkg::FUNC_GET, ste_pkg::FUNC_SET, ste_pkg::FUNC_REMOVE: begin
                     if (idx_ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        res_in.index_error = 1'b1;
                        state_in           = ST_RESULT;
                     end
                  end
                  ste_pkg::FUNC_ADD, ste_pkg::FUNC_FIND: begin
                     if (eff_size != '0) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(eff_size - SW'(1));
                        pos_in      = eff_size - SW'(1);
                        state_in    = ST_SCAN;
                     end else begin
                        state_in = ST_RESULT;
                     end
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (func_ff == ste_pkg::FUNC_GET) begin
               res_in.read_value = rd_wide[ste_pkg::DATA_W-1:0];
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = idx_ff;
               mem_wr_data = new_val;
               if (mem_rd_data == '0 && new_val != '0) begin
                  occ_in = occ_ff + OW'(1);
               end else if (mem_rd_data != '0 && new_val == '0) begin
                  occ_in = occ_ff - OW'(1);
               end
            end
            state_in = ST_RESULT;
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.found        = 1'b1;
               res_in.result_index = ste_pkg::IDX_W'(pos_ff);
               if (func_ff == ste_pkg::FUNC_ADD) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(pos_ff);
                  mem_wr_data = val_ff;
                  if (val_ff != '0) begin
                     occ_in = occ_ff + OW'(1);
                  end
               end
               state_in = ST_RESULT;
            end else if (pos_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(pos_ff - SW'(1));
               pos_in      = pos_ff - SW'(1);
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in                = res_ff;
               rsp_data_in.occupied_count = ste_pkg::CNT_W'(occ_ff);
               rsp_data_in.has_empty      = 32'(occ_ff) < 32'(eff_size);
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.read_value     = rsp_data_ff.read_value;
   assign rsp_ch.result_index   = rsp_data_ff.result_index;
   assign rsp_ch.found          = rsp_data_ff.found;
   assign rsp_ch.index_error    = rsp_data_ff.index_error;
   assign rsp_ch.occupied_count = rsp_data_ff.occupied_count;
   assign rsp_ch.has_empty      = rsp_data_ff.has_empty;

endmodule

// File: sv/slot_table_engine_core.sv
`timescale 1ns / 1ps
// Flow: get, set and remove go through the read state to the result state; an index
// error or an unused code goes straight to the result state; add and find first scan
// top-down, one slot per cycle up to the table size, unless the table size is zero.
// The result state registers the response. One transaction is handled at a time, and
// one waiting response does not hold up the next request.
// After reset the store is cleared with requests refused; table_size is 16.
// ----------------------------------------------------------------------------
// Slot table engine core
// Slot table with get, set, add, remove and find, built around one slot memory.
// ----------------------------------------------------------------------------
module slot_table_engine_core #(
   parameter int SLOTS       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   ste_req_if.sink                    req_ch,
   ste_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [ste_pkg::SIZE_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(SLOTS);

   logic [ste_pkg::SIZE_W-1:0] table_size_ff;
   logic [ste_pkg::SIZE_W-1:0] eff_size;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [VALUE_WIDTH-1:0]     mem_rd_data;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [VALUE_WIDTH-1:0]     mem_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= ste_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         table_size_ff <= csr_wr_data;
      end
   end

   assign eff_size = (32'(table_size_ff) > SLOTS) ? ste_pkg::SIZE_W'(SLOTS) : table_size_ff;

   ste_store #(
      .DEPTH (SLOTS),
      .WIDTH (VALUE_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   ste_seq #(
      .SLOTS       (SLOTS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .eff_size    (eff_size),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The store is being cleared right after reset, so no request may be taken.
   a_no_accept_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request accepted during the clearing pass");

   a_error_is_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.index_error) |->
         (!rsp_ch.found && rsp_ch.read_value == '0 && rsp_ch.result_index == '0))
      else $error("index error response carries other results");

   a_has_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.has_empty == (rsp_ch.occupied_count < eff_size)))
      else $error("has_empty disagrees with the occupied count");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.found) |-> ({1'b0, rsp_ch.result_index} < eff_size))
      else $error("found slot lies outside the table");

endmodule
